FILE: src/ticu_pkg.sv
// ----------------------------------------------------------------------------
// ticu_pkg
// Shared types, codes and helpers of the tiny instruction machine control unit.
// ----------------------------------------------------------------------------
package ticu_pkg;

  localparam int unsigned MEM_DEPTH_DEF  = 2048;
  localparam int unsigned IO_DEPTH_DEF   = 32;
  localparam int unsigned STEP_LIMIT_DEF = 2048;

  localparam int unsigned ADDR_W      = 11;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned OP_W        = 5;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned STEP_W      = 12;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 80;

  localparam logic [STEP_W-1:0] STEP_SAT = 12'hFFF;

  // Item kinds carried in the input tuser.
  localparam logic [FUNC_W-1:0] FUNC_LOAD_MEM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_IO  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXEC     = 2'd2;

  // Run status codes.
  localparam logic [STATUS_W-1:0] RUN_ACTIVE = 2'd0;
  localparam logic [STATUS_W-1:0] RUN_EOP    = 2'd1;
  localparam logic [STATUS_W-1:0] RUN_LIMIT  = 2'd2;

  // Instruction opcodes.
  localparam logic [OP_W-1:0] OP_WM  = 5'h01;
  localparam logic [OP_W-1:0] OP_RM  = 5'h02;
  localparam logic [OP_W-1:0] OP_BR  = 5'h03;
  localparam logic [OP_W-1:0] OP_RIO = 5'h04;
  localparam logic [OP_W-1:0] OP_WIO = 5'h05;
  localparam logic [OP_W-1:0] OP_WB  = 5'h06;
  localparam logic [OP_W-1:0] OP_WIB = 5'h07;
  localparam logic [OP_W-1:0] OP_EOP = 5'h1F;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FETCH_LO,
    ST_DECODE,
    ST_LOAD,
    ST_DONE
  } ticu_state_t;

  typedef struct packed {
    logic clear;
    logic latch_in;
    logic wr_mem_load;
    logic wr_io_load;
    logic fetch;
    logic latch_hi;
    logic exec;
    logic load_result;
    logic capture;
  } ticu_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              running;
    logic [OP_W-1:0]   fetch_op;
    logic              clear_last;
  } ticu_stat_t;

  // Reduces an 11-bit address modulo a constant depth by compare and subtract
  // of the depth shifted up; steps whose shifted depth exceeds the address
  // range fold away at elaboration.
  function automatic logic [ADDR_W-1:0] mod_depth(input logic [ADDR_W-1:0] a,
                                                  input int unsigned depth);
    logic [ADDR_W:0] r;
    r = {1'b0, a};
    for (int k = ADDR_W - 1; k >= 0; k--) begin
      if ((depth << k) < (1 << ADDR_W) && r >= (ADDR_W+1)'(depth << k)) begin
        r = r - (ADDR_W+1)'(depth << k);
      end
    end
    return r[ADDR_W-1:0];
  endfunction

endpackage

FILE: src/ticu_ctrl.sv
// ----------------------------------------------------------------------------
// ticu_ctrl
// Sequencer of the control unit: handshakes, clearing pass and step phases.
// ----------------------------------------------------------------------------
module ticu_ctrl
  import ticu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output ticu_cmd_t  cmd,
  input  ticu_stat_t stat
);

  ticu_state_t state;
  ticu_state_t state_next;
  logic        out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (stat.func == FUNC_EXEC && stat.running) state_next = ST_FETCH_LO;
        else state_next = ST_DONE;
      end
      ST_FETCH_LO: state_next = ST_DECODE;
      ST_DECODE: begin
        if (stat.fetch_op inside {OP_RM, OP_RIO}) state_next = ST_LOAD;
        else state_next = ST_DONE;
      end
      ST_LOAD: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.latch_in = s_tvalid;
      end
      ST_DISPATCH: begin
        cmd.wr_mem_load = (stat.func == FUNC_LOAD_MEM);
        cmd.wr_io_load  = (stat.func == FUNC_LOAD_IO);
        cmd.fetch       = (stat.func == FUNC_EXEC) && stat.running;
      end
      ST_FETCH_LO: begin
        cmd.fetch    = 1'b1;
        cmd.latch_hi = 1'b1;
      end
      ST_DECODE: cmd.exec = 1'b1;
      ST_LOAD:   cmd.load_result = 1'b1;
      ST_DONE:   cmd.capture = !out_valid || m_tready;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/ticu_datapath.sv
// ----------------------------------------------------------------------------
// ticu_datapath
// Machine registers, program/data memory, I/O buffer and result register.
// ----------------------------------------------------------------------------
module ticu_datapath
  import ticu_pkg::*;
#(
  parameter int unsigned MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int unsigned IO_DEPTH   = IO_DEPTH_DEF,
  parameter int unsigned STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [FUNC_W-1:0]      in_tuser,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  ticu_cmd_t              cmd,
  output ticu_stat_t             stat
);

  localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
  localparam int unsigned IO_AW  = $clog2(IO_DEPTH);

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] io_mem [IO_DEPTH];
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] io_rdata;

  logic [FUNC_W-1:0]   in_func;
  logic [ADDR_W-1:0]   in_addr;
  logic [BYTE_W-1:0]   in_data;
  logic [MEM_AW-1:0]   clear_cnt;

  logic [ADDR_W-1:0]   pc;
  logic [WORD_W-1:0]   ir;
  logic [ADDR_W-1:0]   mar;
  logic [ADDR_W-1:0]   mbr;
  logic [ADDR_W-1:0]   ioar;
  logic [ADDR_W-1:0]   iobr;
  logic [STATUS_W-1:0] status;
  logic [STEP_W-1:0]   step_count;

  logic [WORD_W-1:0]   word;
  logic [OP_W-1:0]     op;
  logic [ADDR_W-1:0]   arg;
  logic [STEP_W-1:0]   step_next;
  logic [STATUS_W-1:0] status_next;

  logic                mem_we;
  logic [MEM_AW-1:0]   mem_addr;
  logic [BYTE_W-1:0]   mem_wdata;
  logic                io_we;
  logic [IO_AW-1:0]    io_addr;
  logic [BYTE_W-1:0]   io_wdata;
  logic [ADDR_W-1:0]   mem_sel_addr;
  logic [ADDR_W-1:0]   io_sel_addr;
  logic [ADDR_W-1:0]   mem_mod_addr;
  logic [ADDR_W-1:0]   io_mod_addr;

  // The instruction word is the held high byte and the low byte being read.
  assign word = {ir[WORD_W-1:BYTE_W], mem_rdata};
  assign op   = word[WORD_W-1:ADDR_W];
  assign arg  = word[ADDR_W-1:0];

  assign stat.func       = in_func;
  assign stat.running    = (status == RUN_ACTIVE);
  assign stat.fetch_op   = op;
  assign stat.clear_last = (clear_cnt == MEM_AW'(MEM_DEPTH - 1));

  always_comb begin
    if (cmd.wr_mem_load) mem_sel_addr = in_addr;
    else if (cmd.exec) mem_sel_addr = arg;
    else mem_sel_addr = pc;
    mem_mod_addr = mod_depth(mem_sel_addr, MEM_DEPTH);
    mem_addr  = cmd.clear ? clear_cnt : mem_mod_addr[MEM_AW-1:0];
    mem_we    = cmd.clear || cmd.wr_mem_load || (cmd.exec && op == OP_WM);
    mem_wdata = cmd.clear ? '0 : (cmd.wr_mem_load ? in_data : mbr[BYTE_W-1:0]);

    io_sel_addr = cmd.wr_io_load ? in_addr : arg;
    io_mod_addr = mod_depth(io_sel_addr, IO_DEPTH);
    io_addr  = cmd.clear ? clear_cnt[IO_AW-1:0] : io_mod_addr[IO_AW-1:0];
    io_we    = (cmd.clear && ({1'b0, clear_cnt} < (MEM_AW+1)'(IO_DEPTH)))
            || cmd.wr_io_load || (cmd.exec && op == OP_WIO);
    io_wdata = cmd.clear ? '0 : (cmd.wr_io_load ? in_data : iobr[BYTE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (io_we) io_mem[io_addr] <= io_wdata;
    io_rdata <= io_mem[io_addr];
  end

  always_comb begin
    step_next = (step_count < STEP_SAT) ? step_count + 1'b1 : step_count;
    status_next = (op == OP_EOP) ? RUN_EOP : status;
    if (status_next == RUN_ACTIVE && step_next >= STEP_W'(STEP_LIMIT)) begin
      status_next = RUN_LIMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_func <= in_tuser;
      in_addr <= in_tdata[ADDR_W-1:0];
      in_data <= in_tdata[ADDR_W+BYTE_W-1:ADDR_W];
    end
    if (cmd.capture) begin
      out_tdata <= {2'b00, status, iobr, ioar, mbr, mar, ir[WORD_W-1:ADDR_W], ir, pc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt  <= '0;
      pc         <= '0;
      ir         <= '0;
      mar        <= '0;
      mbr        <= '0;
      ioar       <= '0;
      iobr       <= '0;
      status     <= RUN_ACTIVE;
      step_count <= '0;
    end else begin
      if (cmd.clear) clear_cnt <= clear_cnt + 1'b1;
      if (cmd.fetch) pc <= pc + 1'b1;
      if (cmd.latch_hi) ir[WORD_W-1:BYTE_W] <= mem_rdata;
      if (cmd.exec) begin
        ir         <= word;
        step_count <= step_next;
        status     <= status_next;
        case (op)
          OP_WM:   mar  <= arg;
          OP_RM:   mar  <= arg;
          OP_BR:   pc   <= arg;
          OP_RIO:  ioar <= arg;
          OP_WIO:  ioar <= arg;
          OP_WB:   mbr  <= arg;
          OP_WIB:  iobr <= arg;
          default: ;
        endcase
      end
      if (cmd.load_result) begin
        if (ir[WORD_W-1:ADDR_W] == OP_RM) mbr <= {3'b000, mem_rdata};
        else iobr <= {3'b000, io_rdata};
      end
    end
  end

endmodule

FILE: src/tiny_isa_control_unit.sv
// ----------------------------------------------------------------------------
// tiny_isa_control_unit
// Control unit of a small 16-bit instruction machine with byte memories.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that zeroes the program/data
// memory and the I/O buffer; no item is taken during it. Items then arrive
// on the slave stream: s_tuser selects a memory byte load, an I/O buffer
// byte load or one instruction step, and every item gives exactly one result
// on the master stream with a snapshot of the machine registers and the run
// status. Items are handled one at a time. A load item has dispatch and
// done phases, as does a step while halted; a step adds fetch and decode
// phases, and RM and RIO a load phase, because the single memory port with
// its registered read serves each instruction byte and then the data access,
// and the I/O buffer read is registered too. A new item is accepted while
// the previous result waits in the output register; the block holds in its
// final phase only when that register is still full at the end of an item.
module tiny_isa_control_unit
  import ticu_pkg::*;
#(
  parameter int unsigned MEM_DEPTH  = MEM_DEPTH_DEF,
  parameter int unsigned IO_DEPTH   = IO_DEPTH_DEF,
  parameter int unsigned STEP_LIMIT = STEP_LIMIT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Fields from bit 0 up: load_addr[10:0], load_data[18:11], zero fill.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // Fields from bit 0 up: func[1:0].
  input  logic [FUNC_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Fields from bit 0 up: prog_counter[10:0], instr_word[26:11],
  // opcode[31:27], mem_addr_reg[42:32], mem_buf_reg[53:43],
  // io_addr_reg[64:54], io_buf_reg[75:65], run_status[77:76], zero fill.
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  ticu_cmd_t  cmd;
  ticu_stat_t stat;

  // The sequencer owns the handshakes and the phase of the current item.
  ticu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds all machine state, both stores and the result register.
  ticu_datapath #(
    .MEM_DEPTH  (MEM_DEPTH),
    .IO_DEPTH   (IO_DEPTH),
    .STEP_LIMIT (STEP_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_tdata  (s_tdata),
    .in_tuser  (s_tuser),
    .out_tdata (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: src/ticu_checker.sv
// ----------------------------------------------------------------------------
// ticu_checker
// Port-level checks of the control unit, bound to the top level.
// ----------------------------------------------------------------------------
module ticu_checker
  import ticu_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // Items are handled one at a time, so an accept is never followed directly
  // by another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken in two consecutive cycles");

  // A stalled result stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // The opcode field is the top of the instruction word.
  a_opcode_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:27] == m_tdata[26:22]))
    else $error("opcode does not match instruction word");

  // Run status never shows the unused code and the fill bits stay zero.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[77:76] != 2'b11 && m_tdata[79:78] == 2'b00))
    else $error("bad run status or fill bits");

endmodule

bind tiny_isa_control_unit ticu_checker u_ticu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the tiny instruction machine control unit. A
// shadow copy of the machine predicts the register snapshot that every item
// returns, and a scoreboard compares each snapshot field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ticu_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_TAIL  = 16;
  localparam int unsigned MAX_REPORTS = 10;

  // The fourth item kind has no meaning; the block must answer it unchanged.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One register snapshot, as carried by an output item.
  typedef struct {
    logic [ADDR_W-1:0]   prog_counter;
    logic [WORD_W-1:0]   instr_word;
    logic [OP_W-1:0]     opcode;
    logic [ADDR_W-1:0]   mem_addr_reg;
    logic [ADDR_W-1:0]   mem_buf_reg;
    logic [ADDR_W-1:0]   io_addr_reg;
    logic [ADDR_W-1:0]   io_buf_reg;
    logic [STATUS_W-1:0] run_status;
  } snapshot_t;

  // Shadow machine plus the queue of snapshots that the block still owes.
  // The stimulus also peeks at the shadow state (program counter, memory,
  // status) to steer the program where it wants to go.
  class snapshot_board;
    bit [BYTE_W-1:0]   mem_image [MEM_DEPTH_DEF];
    bit [BYTE_W-1:0]   io_image [IO_DEPTH_DEF];
    bit [ADDR_W-1:0]   pc, mar, mbr, ioar, iobr;
    bit [WORD_W-1:0]   ir;
    bit [STATUS_W-1:0] status;
    bit [STEP_W-1:0]   steps;
    snapshot_t         expected_q[$];
    int unsigned       mismatches;

    function void run_instruction();
      bit [BYTE_W-1:0] hi, lo;
      bit [ADDR_W-1:0] arg;
      hi = mem_image[pc % MEM_DEPTH_DEF];
      pc = pc + 1'b1;
      lo = mem_image[pc % MEM_DEPTH_DEF];
      pc = pc + 1'b1;
      ir = {hi, lo};
      arg = ir[ADDR_W-1:0];
      case (ir[WORD_W-1 -: OP_W])
        OP_WM: begin
          mar = arg;
          mem_image[mar % MEM_DEPTH_DEF] = mbr[BYTE_W-1:0];
        end
        OP_RM: begin
          mar = arg;
          mbr = ADDR_W'(mem_image[mar % MEM_DEPTH_DEF]);
        end
        OP_BR: pc = arg;
        OP_RIO: begin
          ioar = arg;
          iobr = ADDR_W'(io_image[ioar % IO_DEPTH_DEF]);
        end
        OP_WIO: begin
          ioar = arg;
          io_image[ioar % IO_DEPTH_DEF] = iobr[BYTE_W-1:0];
        end
        OP_WB:  mbr = arg;
        OP_WIB: iobr = arg;
        OP_EOP: status = RUN_EOP;
        default: ;
      endcase
      if (steps != STEP_SAT) steps = steps + 1'b1;
      if (status == RUN_ACTIVE && steps >= STEP_LIMIT_DEF) status = RUN_LIMIT;
    endfunction

    function void note_item(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                            logic [BYTE_W-1:0] data);
      snapshot_t s;
      case (func)
        FUNC_LOAD_MEM: mem_image[addr % MEM_DEPTH_DEF] = data;
        FUNC_LOAD_IO:  io_image[addr % IO_DEPTH_DEF] = data;
        FUNC_EXEC:     if (status == RUN_ACTIVE) run_instruction();
        default: ;
      endcase
      s.prog_counter = pc;
      s.instr_word   = ir;
      s.opcode       = ir[WORD_W-1 -: OP_W];
      s.mem_addr_reg = mar;
      s.mem_buf_reg  = mbr;
      s.io_addr_reg  = ioar;
      s.io_buf_reg   = iobr;
      s.run_status   = status;
      expected_q.push_back(s);
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] want,
                                logic [WORD_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
    endfunction

    function void check_snapshot(logic [OUT_TDATA_W-1:0] t);
      snapshot_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing expected: %h", t);
      end else begin
        want = expected_q.pop_front();
        compare_field("prog_counter", WORD_W'(want.prog_counter), WORD_W'(t[10:0]));
        compare_field("instr_word",   want.instr_word,            t[26:11]);
        compare_field("opcode",       WORD_W'(want.opcode),       WORD_W'(t[31:27]));
        compare_field("mem_addr_reg", WORD_W'(want.mem_addr_reg), WORD_W'(t[42:32]));
        compare_field("mem_buf_reg",  WORD_W'(want.mem_buf_reg),  WORD_W'(t[53:43]));
        compare_field("io_addr_reg",  WORD_W'(want.io_addr_reg),  WORD_W'(t[64:54]));
        compare_field("io_buf_reg",   WORD_W'(want.io_buf_reg),   WORD_W'(t[75:65]));
        compare_field("run_status",   WORD_W'(want.run_status),   WORD_W'(t[77:76]));
      end
    endfunction
  endclass

  // Every input is known from time zero; reset starts high.
  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [FUNC_W-1:0]      s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  snapshot_board board = new;

  // While quiet_phase is set, neither side inserts random idle cycles.
  bit          quiet_phase;
  int unsigned cycle_count;
  int unsigned rx_stall;

  tiny_isa_control_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog. It also covers the clearing pass after reset, which holds
  // off the first item.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Output monitor: every accepted result is checked against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_snapshot(m_tdata);
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: ready for a random run of cycles, then a random stall. The
  // two assignments always land on different falling edges.
  always begin
    @(negedge clk);
    m_tready <= 1'b1;
    repeat ($urandom_range(1, 12)) @(negedge clk);
    rx_stall = pick_gap();
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      repeat (rx_stall) @(negedge clk);
    end
  end

  // A random instruction that is never EOP. Known opcodes dominate; the
  // rest is any code below EOP, unknown ones included. Operands lean toward
  // the extremes now and then.
  function automatic logic [WORD_W-1:0] random_word();
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] arg;
    case ($urandom_range(0, 15))
      0, 1:    op = OP_WM;
      2, 3:    op = OP_RM;
      4, 5:    op = OP_RIO;
      6, 7:    op = OP_WIO;
      8, 9:    op = OP_WB;
      10, 11:  op = OP_WIB;
      12:      op = OP_BR;
      default: op = OP_W'($urandom_range(0, OP_EOP - 1));
    endcase
    case ($urandom_range(0, 9))
      0:       arg = '0;
      1:       arg = '1;
      default: arg = ADDR_W'($urandom);
    endcase
    return {op, arg};
  endfunction

  // Sends one item after a random gap and returns at the rising edge that
  // accepts it. The valid stays high so that a following item with no gap
  // goes out back to back.
  task automatic send_item(input logic [FUNC_W-1:0] func,
                           input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= IN_TDATA_W'({data, addr});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(func, addr, data);
  endtask

  // Places an instruction word big-endian at addr, wrapping at 11 bits.
  task automatic load_word(input logic [ADDR_W-1:0] addr,
                           input logic [WORD_W-1:0] word);
    send_item(FUNC_LOAD_MEM, addr, word[WORD_W-1:BYTE_W]);
    send_item(FUNC_LOAD_MEM, ADDR_W'(addr + 1), word[BYTE_W-1:0]);
  endtask

  // One step item. Unless an EOP is wanted, an EOP waiting at the program
  // counter is replaced first so the machine keeps running.
  task automatic step_machine(input bit allow_eop);
    logic [WORD_W-1:0] w;
    w = random_word();
    if (board.status == RUN_ACTIVE && !allow_eop &&
        board.mem_image[board.pc][BYTE_W-1 -: OP_W] == OP_EOP)
      send_item(FUNC_LOAD_MEM, board.pc, w[WORD_W-1:BYTE_W]);
    send_item(FUNC_EXEC, ADDR_W'($urandom), BYTE_W'($urandom));
  endtask

  task automatic run_word(input logic [WORD_W-1:0] word);
    load_word(board.pc, word);
    step_machine(1'b0);
  endtask

  // Lowers valid and holds the sender until every snapshot has come back.
  task automatic idle_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned       r, len, i;
    logic [ADDR_W-1:0] base;
    logic [WORD_W-1:0] w;
    bit                drained_mid;

    drained_mid = 1'b0;
    quiet_phase = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Load extremes: top address with all-ones data, and an
    // I/O load whose address only keeps its low five bits.
    send_item(FUNC_LOAD_MEM, '1, '1);
    send_item(FUNC_LOAD_IO, '1, 8'hA5);
    send_item(FUNC_UNUSED, '1, '1);
    // A step over cleared memory fetches the unknown opcode zero.
    step_machine(1'b0);
    // Every defined operation but EOP with extreme operands. WIO at 0x7E0
    // lands on I/O entry zero while the address register keeps all eleven bits.
    run_word({OP_WB,  11'h7FF});
    run_word({OP_WM,  11'h7FF});
    run_word({OP_RM,  11'h7FF});
    run_word({OP_WIB, 11'h7FF});
    run_word({OP_WIO, 11'h7E0});
    run_word({OP_RIO, 11'h01F});
    // Branch to the top byte: the next word straddles the wrap of the
    // program counter from 0x7FF to zero.
    run_word({OP_BR,  11'h7FF});
    run_word({OP_WB,  11'h2AA});

    // Random part. Mostly steps through small looping programs, mixed with
    // stray loads, the unused item kind and now and then a fresh program.
    // It runs until one step is left before the step limit.
    while (board.steps < STEP_LIMIT_DEF - 1) begin
      if ($urandom_range(0, 149) == 0) quiet_phase = !quiet_phase;
      // Halfway through, the sender waits for every result once.
      if (!drained_mid && board.steps >= STEP_LIMIT_DEF / 2) begin
        idle_until_drained();
        drained_mid = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 1) begin
        // A program of a few words at the program counter, closed by a
        // branch back to its start.
        base = board.pc;
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) load_word(ADDR_W'(base + 2 * i), random_word());
        load_word(ADDR_W'(base + 2 * len), {OP_BR, base});
      end else if (r < 2) begin
        send_item(FUNC_LOAD_MEM, ADDR_W'($urandom), BYTE_W'($urandom));
      end else if (r < 3) begin
        send_item(FUNC_LOAD_IO, ADDR_W'($urandom), BYTE_W'($urandom));
      end else if (r < 4) begin
        send_item(FUNC_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom));
      end else begin
        // Cleared memory gives only no-ops, so empty words now and then get
        // filled.
        if (board.mem_image[board.pc] == 0 &&
            board.mem_image[ADDR_W'(board.pc + 1)] == 0 &&
            $urandom_range(0, 15) == 0)
          load_word(board.pc, random_word());
        step_machine(1'b0);
      end
    end

    // The last allowed step: either an EOP, which still counts as success,
    // or any other instruction, which ends the run on the step limit.
    quiet_phase = 1'b0;
    if ($urandom_range(0, 1)) w = {OP_EOP, ADDR_W'($urandom)};
    else w = random_word();
    load_word(board.pc, w);
    step_machine(1'b1);

    // Halted: steps must leave everything alone, loads still go in.
    for (i = 0; i < 24; i++) begin
      case ($urandom_range(0, 3))
        0: send_item(FUNC_LOAD_MEM, ADDR_W'($urandom), BYTE_W'($urandom));
        1: send_item(FUNC_LOAD_IO, ADDR_W'($urandom), BYTE_W'($urandom));
        2: send_item(FUNC_UNUSED, ADDR_W'($urandom), BYTE_W'($urandom));
        default: step_machine(1'b1);
      endcase
    end

    idle_until_drained();
    repeat (DRAIN_TAIL) @(negedge clk);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
